### design/double_ended_sorted_priority_queue_assert.svh
// assertion macros for the double-ended sorted priority queue
`ifndef DOUBLE_ENDED_SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_SORTED_PRIORITY_QUEUE_ASSERT_SVH

// condition holds in the same cycle
`define DSQ_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("dsq: same-cycle check failed");

// condition implies a result on the next cycle
`define DSQ_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("dsq: next-cycle check failed");

`endif

### design/dsq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dsq_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int OCC_W = 5;
  localparam int DATA_W = 32;

  localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -1;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_FRONT  = 2'd1,
    FUNC_REAR   = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic insert;
    logic pop_front;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### design/double_ended_sorted_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none
`include "double_ended_sorted_priority_queue_assert.svh"

// Double-ended priority queue holding up to DEPTH signed 32-bit values in a
// row of cells kept in ascending order. Every cell compares its value with
// the incoming one, so an insert shifts the greater entries one place to the
// rear; a front removal shifts the whole row one place to the front; a rear
// removal only drops the count. One request is taken per cycle and each
// gives one result in the next cycle from the output register;
// requests stall only while that register holds a result that is itself
// stalled. There is no clearing pass after reset.
module double_ended_sorted_priority_queue (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        func,
  input  wire logic signed [dsq_pkg::DATA_W-1:0] value_in,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [dsq_pkg::DATA_W-1:0]      value_out,
  output logic [1:0]                             status,
  output logic [dsq_pkg::OCC_W-1:0]              occupancy
);

  localparam int DEPTH = dsq_pkg::DEPTH;
  localparam int CNT_W = dsq_pkg::CNT_W;
  localparam int DATA_W = dsq_pkg::DATA_W;

  logic                     accept;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic                     full;
  logic                     empty;
  dsq_pkg::cell_ctrl_t      ctrl;
  logic signed [DATA_W-1:0] cell_value [DEPTH];
  logic [DEPTH-1:0]         cell_gt;
  logic signed [DATA_W-1:0] rear_value;
  logic signed [DATA_W-1:0] result;
  dsq_pkg::status_t         result_status;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);

  always_comb begin
    ctrl          = '0;
    count_next    = count;
    result        = '0;
    result_status = dsq_pkg::ST_DONE;
    case (func)
      dsq_pkg::FUNC_INSERT: begin
        if (full) begin
          result_status = dsq_pkg::ST_FULL;
        end else begin
          ctrl.insert = accept;
          count_next  = count + 1'b1;
        end
      end
      dsq_pkg::FUNC_FRONT: begin
        if (empty) begin
          result        = dsq_pkg::EMPTY_VALUE;
          result_status = dsq_pkg::ST_EMPTY;
        end else begin
          ctrl.pop_front = accept;
          result         = cell_value[0];
          count_next     = count - 1'b1;
        end
      end
      dsq_pkg::FUNC_REAR: begin
        if (empty) begin
          result        = dsq_pkg::EMPTY_VALUE;
          result_status = dsq_pkg::ST_EMPTY;
        end else begin
          result     = rear_value;
          count_next = count - 1'b1;
        end
      end
      default: begin
        // unused code leaves the queue alone
        result = '0;
      end
    endcase
  end

  // last occupied cell drives the rear value
  always_comb begin
    rear_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (CNT_W'(i + 1) == count) begin
        rear_value = rear_value | cell_value[i];
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_value;
    logic                     left_gt;
    logic signed [DATA_W-1:0] right_value;

    if (i == 0) begin : g_first
      assign left_value = '0;
      assign left_gt    = 1'b0;
    end else begin : g_inner
      assign left_value = cell_value[i-1];
      assign left_gt    = cell_gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_value = cell_value[i];
    end else begin : g_mid
      assign right_value = cell_value[i+1];
    end

    dsq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (CNT_W'(i) < count),
      .new_value   (value_in),
      .left_value  (left_value),
      .left_gt     (left_gt),
      .right_value (right_value),
      .value       (cell_value[i]),
      .gt          (cell_gt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else if (accept) begin
      count     <= count_next;
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_out <= result;
      status    <= result_status;
      occupancy <= dsq_pkg::OCC_W'(count_next);
    end
  end

  `DSQ_ASSERT_NOW(a_count_range, 1'b1, count <= CNT_W'(DEPTH))
  `DSQ_ASSERT_NEXT(a_empty_removal,
    accept && empty && (func == dsq_pkg::FUNC_FRONT || func == dsq_pkg::FUNC_REAR),
    status == dsq_pkg::ST_EMPTY && value_out == dsq_pkg::EMPTY_VALUE && count == '0)
  `DSQ_ASSERT_NEXT(a_full_insert, accept && full && func == dsq_pkg::FUNC_INSERT,
    status == dsq_pkg::ST_FULL && count == $past(count))
  `DSQ_ASSERT_NEXT(a_front_value, accept && !empty && func == dsq_pkg::FUNC_FRONT,
    value_out == $past(cell_value[0]) && count == $past(count) - 1'b1)

endmodule

`default_nettype wire

### design/dsq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module dsq_cell (
  input  wire logic                              clk,
  input  wire dsq_pkg::cell_ctrl_t               ctrl,
  input  wire logic                              occ,
  input  wire logic signed [dsq_pkg::DATA_W-1:0] new_value,
  input  wire logic signed [dsq_pkg::DATA_W-1:0] left_value,
  input  wire logic                              left_gt,
  input  wire logic signed [dsq_pkg::DATA_W-1:0] right_value,
  output logic signed [dsq_pkg::DATA_W-1:0]      value,
  output logic                                   gt
);

  // empty slots count as greater so the new value lands in the first free one
  assign gt = !occ || (value > new_value);

  always_ff @(posedge clk) begin
    if (ctrl.insert && gt) begin
      value <= left_gt ? left_value : new_value;
    end else if (ctrl.pop_front) begin
      value <= right_value;
    end
  end

endmodule

`default_nettype wire
